### rtl/hsvv_pkg.sv
`default_nettype none

package hsvv_pkg;

   localparam int RADIUS_PIX  = 8;
   localparam int RADIUS_SQ   = RADIUS_PIX * RADIUS_PIX;
   localparam int NUM_COLOURS = 6;
   localparam int NUM_BOXES   = 8;
   localparam int BOX_W       = 48;
   localparam int CSR_IDX_W   = 3;
   localparam int COUNT_W     = 10;
   localparam int COLOUR_W    = 3;
   localparam int DIV_STEPS   = 8;
   localparam int DIV_STEP_W  = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] BOX_WHITE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] BOX_RED_A    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] BOX_RED_B    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] BOX_BLUE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] BOX_GREEN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] BOX_ORANGE_A = 3'd5;
   localparam logic [CSR_IDX_W-1:0] BOX_ORANGE_B = 3'd6;
   localparam logic [CSR_IDX_W-1:0] BOX_YELLOW   = 3'd7;

   // colour codes
   localparam logic [COLOUR_W-1:0] COL_BLUE   = 3'd0;
   localparam logic [COLOUR_W-1:0] COL_GREEN  = 3'd1;
   localparam logic [COLOUR_W-1:0] COL_ORANGE = 3'd2;
   localparam logic [COLOUR_W-1:0] COL_RED    = 3'd3;
   localparam logic [COLOUR_W-1:0] COL_WHITE  = 3'd4;
   localparam logic [COLOUR_W-1:0] COL_YELLOW = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_SAT_GO,
      ST_SAT_WAIT,
      ST_HUE_GO,
      ST_HUE_WAIT,
      ST_COUNT,
      ST_VOTE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic div_start;
      logic div_hue;
      logic sat_latch;
      logic hue_latch;
      logic count;
      logic vote_init;
      logic vote_step;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic last_pixel;
      logic vote_last;
      logic out_free;
   } dp_status_type;

   function automatic logic in_box(input logic [BOX_W-1:0] box,
                                   input logic [7:0] h,
                                   input logic [7:0] s,
                                   input logic [7:0] v);
      logic ok_h;
      logic ok_s;
      logic ok_v;
      ok_h = (h >= box[7:0])   && (h <= box[31:24]);
      ok_s = (s >= box[15:8])  && (s <= box[39:32]);
      ok_v = (v >= box[23:16]) && (v <= box[47:40]);
      return ok_h && ok_s && ok_v;
   endfunction

endpackage

`default_nettype wire

### rtl/hsvv_div.sv
`default_nettype none

module hsvv_div
   import hsvv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [16:0] dividend,
   input  logic [8:0]  divisor,
   output logic [7:0]  quotient,
   output logic        done
);

   logic [16:0]           rem_ff;
   logic [15:0]           dsr_ff;
   logic [7:0]            quo_ff;
   logic [DIV_STEP_W-1:0] step_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic                  fits;

   // quotient is known to stay below 256, so eight restoring steps suffice
   assign fits = rem_ff >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == DIV_STEP_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         dsr_ff <= {divisor, 7'd0};
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? (rem_ff - {1'b0, dsr_ff}) : rem_ff;
         dsr_ff <= dsr_ff >> 1;
         quo_ff <= {quo_ff[6:0], fits};
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a run");

endmodule

`default_nettype wire

### rtl/hsvv_dp.sv
`default_nettype none

module hsvv_dp
   import hsvv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           pix_blue,
   input  logic [7:0]           pix_green,
   input  logic [7:0]           pix_red,
   input  logic signed [4:0]    off_x,
   input  logic signed [4:0]    off_y,
   input  logic                 pix_last,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BOX_W-1:0]     csr_wdata,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   input  logic                 rsp_tready,
   output logic                 rsp_valid,
   output logic [COLOUR_W-1:0]  rsp_colour,
   output logic [COUNT_W-1:0]   rsp_count
);

   logic [7:0]        b_ff, g_ff, r_ff;
   logic signed [4:0] dx_ff, dy_ff;
   logic              last_ff;

   logic [7:0]         v_ff, d_ff;
   logic signed [11:0] n_ff;
   logic               circ_ff;
   logic [7:0]         sat_ff, hue_ff;

   logic [BOX_W-1:0]   box_ff [NUM_BOXES];
   logic [COUNT_W-1:0] cnt_ff [NUM_COLOURS];
   logic [COUNT_W-1:0] cnt_in [NUM_COLOURS];

   logic [COUNT_W-1:0]  best_ff;
   logic [COLOUR_W-1:0] bidx_ff;
   logic [COLOUR_W-1:0] vidx_ff;

   logic                rsp_valid_ff;
   logic [COLOUR_W-1:0] rsp_colour_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   // HSV front end
   logic [7:0]         vmax_in, vmin_in, d_in;
   logic signed [11:0] b12, g12, r12, d12, n_in;
   logic signed [9:0]  dx_sq, dy_sq;
   logic [10:0]        circ_sum;

   always_comb begin
      vmax_in = b_ff;
      if (g_ff > vmax_in) vmax_in = g_ff;
      if (r_ff > vmax_in) vmax_in = r_ff;
      vmin_in = b_ff;
      if (g_ff < vmin_in) vmin_in = g_ff;
      if (r_ff < vmin_in) vmin_in = r_ff;
      d_in = vmax_in - vmin_in;
      b12  = $signed({4'd0, b_ff});
      g12  = $signed({4'd0, g_ff});
      r12  = $signed({4'd0, r_ff});
      d12  = $signed({4'd0, d_in});
      if (vmax_in == r_ff) begin
         n_in = g12 - b12;
      end else if (vmax_in == g_ff) begin
         n_in = b12 - r12 + (d12 <<< 1);
      end else begin
         n_in = r12 - g12 + (d12 <<< 2);
      end
   end

   assign dx_sq    = dx_ff * dx_ff;
   assign dy_sq    = dy_ff * dy_ff;
   assign circ_sum = {1'b0, dx_sq} + {1'b0, dy_sq};

   // divider operands
   logic [16:0]        sat_num, hue_num, div_num;
   logic [8:0]         div_den;
   logic signed [17:0] d18, hue_x, hue_wrap;
   logic [7:0]         quo;
   logic               div_done;

   assign d18      = $signed({10'd0, d_ff});
   assign sat_num  = ({9'd0, d_ff} * 17'd255) + {10'd0, v_ff[7:1]};
   assign hue_x    = (18'(n_ff) * 18'sd60) + d18;
   assign hue_wrap = hue_x + (d18 * 18'sd360);
   assign hue_num  = hue_x[17] ? hue_wrap[16:0] : hue_x[16:0];
   assign div_num  = cmd.div_hue ? hue_num : sat_num;
   assign div_den  = cmd.div_hue ? {d_ff, 1'b0} : {1'b0, v_ff};

   hsvv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (quo),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         b_ff    <= pix_blue;
         g_ff    <= pix_green;
         r_ff    <= pix_red;
         dx_ff   <= off_x;
         dy_ff   <= off_y;
         last_ff <= pix_last;
      end
      if (cmd.prep) begin
         v_ff    <= vmax_in;
         d_ff    <= d_in;
         n_ff    <= n_in;
         circ_ff <= (circ_sum <= 11'(RADIUS_SQ));
      end
      if (cmd.sat_latch) sat_ff <= (v_ff == 8'd0) ? 8'd0 : quo;
      if (cmd.hue_latch) hue_ff <= (d_ff == 8'd0) ? 8'd0 : quo;
   end

   // box registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BOXES; i++) box_ff[i] <= '0;
      end else if (csr_wr_en) begin
         box_ff[csr_index] <= csr_wdata;
      end
   end

   // colour masks and counters
   logic [NUM_COLOURS-1:0] mask;

   always_comb begin
      mask[COL_BLUE]   = in_box(box_ff[BOX_BLUE], hue_ff, sat_ff, v_ff);
      mask[COL_GREEN]  = in_box(box_ff[BOX_GREEN], hue_ff, sat_ff, v_ff);
      mask[COL_ORANGE] = in_box(box_ff[BOX_ORANGE_A], hue_ff, sat_ff, v_ff)
                      || in_box(box_ff[BOX_ORANGE_B], hue_ff, sat_ff, v_ff);
      mask[COL_RED]    = in_box(box_ff[BOX_RED_A], hue_ff, sat_ff, v_ff)
                      || in_box(box_ff[BOX_RED_B], hue_ff, sat_ff, v_ff);
      mask[COL_WHITE]  = in_box(box_ff[BOX_WHITE], hue_ff, sat_ff, v_ff);
      mask[COL_YELLOW] = in_box(box_ff[BOX_YELLOW], hue_ff, sat_ff, v_ff);
   end

   always_comb begin
      for (int i = 0; i < NUM_COLOURS; i++) begin
         cnt_in[i] = cnt_ff[i];
         if (cmd.emit) begin
            cnt_in[i] = '0;
         end else if (cmd.count && circ_ff && mask[i] && (cnt_ff[i] != COUNT_MAX)) begin
            cnt_in[i] = cnt_ff[i] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COLOURS; i++) cnt_ff[i] <= '0;
      end else begin
         for (int i = 0; i < NUM_COLOURS; i++) cnt_ff[i] <= cnt_in[i];
      end
   end

   // vote sweep, one counter per cycle
   logic [COUNT_W-1:0] vote_cur;

   assign vote_cur = (vidx_ff < COLOUR_W'(NUM_COLOURS)) ? cnt_ff[vidx_ff] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vidx_ff <= '0;
      end else if (cmd.vote_init) begin
         vidx_ff <= '0;
      end else if (cmd.vote_step) begin
         vidx_ff <= vidx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.vote_init) begin
         best_ff <= '0;
         bidx_ff <= COL_BLUE;
      end else if (cmd.vote_step && (vote_cur > best_ff)) begin
         best_ff <= vote_cur;
         bidx_ff <= vidx_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_colour_ff <= bidx_ff;
         rsp_count_ff  <= best_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_colour = rsp_colour_ff;
   assign rsp_count  = rsp_count_ff;

   assign status.div_done   = div_done;
   assign status.last_pixel = last_ff;
   assign status.vote_last  = (vidx_ff == COLOUR_W'(NUM_COLOURS - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   logic cnt_all_zero;

   always_comb begin
      cnt_all_zero = 1'b1;
      for (int i = 0; i < NUM_COLOURS; i++) begin
         if (cnt_ff[i] != '0) cnt_all_zero = 1'b0;
      end
   end

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result written over a pending transfer");

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> cnt_all_zero)
      else $error("counters not cleared after result");

   a_vote_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.vote_step |-> (vidx_ff < COLOUR_W'(NUM_COLOURS)))
      else $error("vote sweep past last counter");

endmodule

`default_nettype wire

### rtl/hsvv_ctrl.sv
`default_nettype none

module hsvv_ctrl
   import hsvv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_SAT_GO;
         end
         ST_SAT_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_SAT_WAIT;
         end
         ST_SAT_WAIT: begin
            if (status.div_done) begin
               cmd.sat_latch = 1'b1;
               state_in      = ST_HUE_GO;
            end
         end
         ST_HUE_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_hue   = 1'b1;
            state_in      = ST_HUE_WAIT;
         end
         ST_HUE_WAIT: begin
            if (status.div_done) begin
               cmd.hue_latch = 1'b1;
               state_in      = ST_COUNT;
            end
         end
         ST_COUNT: begin
            cmd.count = 1'b1;
            if (status.last_pixel) begin
               cmd.vote_init = 1'b1;
               state_in      = ST_VOTE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_VOTE: begin
            cmd.vote_step = 1'b1;
            if (status.vote_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/hsv_region_color_vote_core.sv
`default_nettype none

// channel  dir  ports                          payload
// req      in   req_tvalid/tready/tdata/tlast  one pixel, tlast = last of window
// rsp      out  rsp_tvalid/tready/tdata        winning colour and its count
// csr      in   csr_wr_en/index/wdata          HSV box registers 0..7
//
// A pixel goes through load, prep, then two 8-step runs of the shared
// restoring divider (saturation, hue), each with a start and a wait for done,
// then the count step. The last pixel of a window adds a vote sweep over
// the six counters and the loading of the result register.
// Reset clears box registers, counters and control; no clearing pass.
// A pending result stalls the block only at the point of loading the next one.

module hsv_region_color_vote_core
   import hsvv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // [7:0] pixel_blue, [15:8] pixel_green, [23:16] pixel_red,
   // [28:24] offset_x, [33:29] offset_y, [39:34] zero
   input  logic [39:0]          req_tdata,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [2:0] colour_index, [12:3] winning_count, [15:13] zero
   output logic [15:0]          rsp_tdata,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BOX_W-1:0]     csr_wdata
);

   dp_cmd_type          cmd;
   dp_status_type       status;
   logic [COLOUR_W-1:0] rsp_colour;
   logic [COUNT_W-1:0]  rsp_count;

   hsvv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hsvv_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .pix_blue   (req_tdata[7:0]),
      .pix_green  (req_tdata[15:8]),
      .pix_red    (req_tdata[23:16]),
      .off_x      ($signed(req_tdata[28:24])),
      .off_y      ($signed(req_tdata[33:29])),
      .pix_last   (req_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_colour (rsp_colour),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = {3'd0, rsp_count, rsp_colour};

endmodule

`default_nettype wire
